[sv/eap_pkg.sv]
// Shared constants, codes and state types for the eased animation progress core.
// Depends on nothing; every other file of the block depends on it.
`default_nettype none

package eap_pkg;

   // Default fraction width of the progress value (Q0.16, one extra bit for 1.0).
   localparam int FRAC_BITS_DEF = 16;

   // Widths fixed by the item and register fields.
   localparam int OP_W    = 2;
   localparam int TIME_W  = 32;
   localparam int DUR_W   = 16;
   localparam int MODE_W  = 3;
   localparam int CSR_W   = 16;
   localparam int CSR_IDX_W = 1;

   // Request operation codes.
   localparam logic [OP_W-1:0] OP_START = 2'd0;
   localparam logic [OP_W-1:0] OP_STOP  = 2'd1;
   localparam logic [OP_W-1:0] OP_TICK  = 2'd2;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] REG_DURATION = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_EASING   = 1'b1;

   // Easing curve codes.
   localparam logic [MODE_W-1:0] EASE_LINEAR    = 3'd0;
   localparam logic [MODE_W-1:0] EASE_QUAD_IN   = 3'd1;
   localparam logic [MODE_W-1:0] EASE_QUAD_OUT  = 3'd2;
   localparam logic [MODE_W-1:0] EASE_QUAD_IO   = 3'd3;
   localparam logic [MODE_W-1:0] EASE_CUBIC_IN  = 3'd4;
   localparam logic [MODE_W-1:0] EASE_CUBIC_OUT = 3'd5;
   localparam logic [MODE_W-1:0] EASE_CUBIC_IO  = 3'd6;
   localparam logic [MODE_W-1:0] EASE_BOUNCE    = 3'd7;

   // Main sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EVAL,
      ST_DIV,
      ST_EASE,
      ST_DONE
   } ctrl_state_type;

   // Easing unit states.
   typedef enum logic [2:0] {
      E_IDLE,
      E_MUL1,
      E_RND1,
      E_MUL2,
      E_RND2
   } ease_state_type;

endpackage

`default_nettype wire

[sv/eap_if.sv]
// Valid/ready channel interfaces for request and response beats.
// Depends on eap_pkg for field widths.
`default_nettype none

interface eap_req_if;
   logic                       valid;
   logic                       ready;
   logic [eap_pkg::OP_W-1:0]   op;
   logic [eap_pkg::TIME_W-1:0] current_time;

   modport source (output valid, output op, output current_time, input ready);
   modport sink   (input valid, input op, input current_time, output ready);
endinterface

interface eap_rsp_if #(
   parameter int FRAC_BITS = eap_pkg::FRAC_BITS_DEF
);
   logic               valid;
   logic               ready;
   logic [FRAC_BITS:0] progress;
   logic               running;
   logic               active;

   modport source (output valid, output progress, output running, output active,
                   input ready);
   modport sink   (input valid, input progress, input running, input active,
                   output ready);
endinterface

`default_nettype wire

[sv/eased_animation_progress_core.sv]
// Eased animation progress core: start, stop and tick beats in, one progress beat out each.
// Start, stop, an idle tick or a finishing tick go from ST_EVAL straight to ST_DONE.
// A running tick passes from ST_EVAL through ST_DIV and ST_EASE to ST_DONE, held up
// by the one-bit-per-cycle divider and the shared multiplier of the easing unit.
// One beat is in work at a time: the next is accepted only once ST_DONE loads the response.
// Reset is synchronous and active high and clears the configuration and animation registers, flags and sequencers.
`default_nettype none

module eased_animation_progress_core #(
   parameter int FRAC_BITS = eap_pkg::FRAC_BITS_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   eap_req_if.sink                              req_bus,
   eap_rsp_if.source                            rsp_bus,
   input  wire logic                            csr_we,
   input  wire logic [eap_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [eap_pkg::CSR_W-1:0]       csr_wdata
);
   import eap_pkg::*;

   localparam logic [FRAC_BITS:0] PROG_ONE = (FRAC_BITS+1)'(1) << FRAC_BITS;

   ctrl_state_type state_ff, state_in;

   // Configuration registers.
   logic [DUR_W-1:0]  duration_ff;
   logic [MODE_W-1:0] easing_ff;

   // Animation state.
   logic [TIME_W-1:0] start_stamp_ff;
   logic [FRAC_BITS:0] progress_ff;
   logic              active_ff;
   logic              running_ff;

   // Latched request beat.
   logic [OP_W-1:0]   op_ff;
   logic [TIME_W-1:0] time_ff;

   // Response register.
   logic              rsp_valid_ff;
   logic [FRAC_BITS:0] rsp_progress_ff;
   logic              rsp_running_ff;
   logic              rsp_active_ff;

   logic [TIME_W-1:0] elapsed;
   logic              finished;
   logic              tick_runs;
   logic              req_ready;
   logic              div_start;
   logic              ease_start;
   logic              out_load;
   logic              out_free;

   logic              div_done;
   logic [FRAC_BITS-1:0] div_quotient;
   logic              ease_done;
   logic [FRAC_BITS:0] ease_result;

   // Elapsed time wraps modulo 2^32. An active tick that has not reached the duration runs
   // through the divider and the easing unit; a zero duration always finishes here.
   always_comb begin
      elapsed   = time_ff - start_stamp_ff;
      finished  = elapsed >= TIME_W'(duration_ff);
      tick_runs = (op_ff == OP_TICK) && active_ff && !finished;
      out_free  = !rsp_valid_ff || rsp_bus.ready;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_bus.valid) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: state_in = tick_runs ? ST_DIV : ST_DONE;
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_EASE;
            end
         end
         ST_EASE: begin
            if (ease_done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready  = 1'b0;
      div_start  = 1'b0;
      ease_start = 1'b0;
      out_load   = 1'b0;
      unique case (state_ff)
         ST_IDLE: req_ready  = 1'b1;
         ST_EVAL: div_start  = tick_runs;
         ST_DIV:  ease_start = div_done;
         ST_EASE: out_load   = 1'b0;
         ST_DONE: out_load   = out_free;
         default: req_ready  = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Configuration writes take effect at once; the host must issue them only while no beat
   // is in work. The block itself does not enforce this.
   always_ff @(posedge clock) begin
      if (reset) begin
         duration_ff <= '0;
         easing_ff   <= EASE_LINEAR;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_DURATION: duration_ff <= csr_wdata;
            REG_EASING:   easing_ff   <= csr_wdata[MODE_W-1:0];
            default:      duration_ff <= duration_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_bus.valid) begin
         op_ff   <= req_bus.op;
         time_ff <= req_bus.current_time;
      end
   end

   // Start restarts even an active animation; stop keeps the last progress value;
   // a tick while inactive and the unused op code leave all but the running flag alone.
   always_ff @(posedge clock) begin
      if (reset) begin
         start_stamp_ff <= '0;
         progress_ff    <= '0;
         active_ff      <= 1'b0;
         running_ff     <= 1'b0;
      end else if (state_ff == ST_EVAL) begin
         running_ff <= 1'b0;
         case (op_ff)
            OP_START: begin
               start_stamp_ff <= time_ff;
               progress_ff    <= '0;
               active_ff      <= 1'b1;
            end
            OP_STOP: active_ff <= 1'b0;
            OP_TICK: begin
               if (active_ff && finished) begin
                  progress_ff <= PROG_ONE;
                  active_ff   <= 1'b0;
               end
            end
            default: active_ff <= active_ff;
         endcase
      end else if ((state_ff == ST_EASE) && ease_done) begin
         progress_ff <= ease_result;
         running_ff  <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_progress_ff <= progress_ff;
         rsp_running_ff  <= running_ff;
         rsp_active_ff   <= active_ff;
      end
   end

   eap_div #(
      .FRAC_BITS (FRAC_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (elapsed[DUR_W-1:0]),
      .divisor  (duration_ff),
      .done     (div_done),
      .quotient (div_quotient)
   );

   eap_ease #(
      .FRAC_BITS (FRAC_BITS)
   ) u_ease (
      .clock  (clock),
      .reset  (reset),
      .start  (ease_start),
      .mode   (easing_ff),
      .t      (div_quotient),
      .done   (ease_done),
      .result (ease_result)
   );

   assign req_bus.ready    = req_ready;
   assign rsp_bus.valid    = rsp_valid_ff;
   assign rsp_bus.progress = rsp_progress_ff;
   assign rsp_bus.running  = rsp_running_ff;
   assign rsp_bus.active   = rsp_active_ff;

endmodule

`default_nettype wire

[sv/eap_div.sv]
// Restoring serial divider: floor((elapsed << FRAC_BITS) / duration), one bit per cycle.
// Depends on eap_pkg; used by the top level of the eased animation progress core.
`default_nettype none

module eap_div #(
   parameter int FRAC_BITS = eap_pkg::FRAC_BITS_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [eap_pkg::DUR_W-1:0]   dividend,
   input  wire logic [eap_pkg::DUR_W-1:0]   divisor,
   output logic                             done,
   output logic [FRAC_BITS-1:0]             quotient
);
   import eap_pkg::*;

   localparam int CW = $clog2(FRAC_BITS + 1);

   logic [DUR_W-1:0]     rem_ff, rem_in;
   logic [DUR_W-1:0]     div_ff;
   logic [FRAC_BITS-1:0] quo_ff, quo_in;
   logic [CW-1:0]        cnt_ff;
   logic                 busy_ff;
   logic                 done_ff;
   logic [DUR_W:0]       shifted;
   logic [DUR_W:0]       diff;
   logic                 fits;

   // The remainder stays below the divisor, so its doubled value fits one extra bit.
   always_comb begin
      shifted = {rem_ff, 1'b0};
      diff    = shifted - {1'b0, div_ff};
      fits    = shifted >= {1'b0, div_ff};
      rem_in  = fits ? diff[DUR_W-1:0] : shifted[DUR_W-1:0];
      quo_in  = {quo_ff[FRAC_BITS-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= busy_ff && (cnt_ff == CW'(1));
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CW'(FRAC_BITS);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - CW'(1);
            if (cnt_ff == CW'(1)) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= dividend;
         div_ff <= divisor;
         quo_ff <= '0;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

[sv/eap_ease.sv]
// Easing unit: applies one of eight curves to t with a single shared registered multiplier.
// Depends on eap_pkg; used by the top level of the eased animation progress core.
`default_nettype none

module eap_ease #(
   parameter int FRAC_BITS = eap_pkg::FRAC_BITS_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire logic [eap_pkg::MODE_W-1:0]   mode,
   input  wire logic [FRAC_BITS-1:0]         t,
   output logic                              done,
   output logic [FRAC_BITS:0]                result
);
   import eap_pkg::*;

   localparam int XW = FRAC_BITS + 3;
   localparam int PW = 2 * XW;
   localparam int WW = FRAC_BITS + 5;

   localparam logic [XW-1:0] ONE   = XW'(1) << FRAC_BITS;
   localparam logic [XW-1:0] HALF  = ONE >> 1;
   localparam logic [XW-1:0] BASE1 = (ONE >> 2) * XW'(3);
   localparam logic [XW-1:0] BASE2 = (ONE >> 4) * XW'(15);
   localparam logic [XW-1:0] BASE3 = (ONE >> 6) * XW'(63);
   localparam logic [WW-1:0] W_ONE = WW'(1) << FRAC_BITS;
   localparam logic [PW:0]   RND_HALF   = (PW+1)'(HALF);
   localparam logic [PW:0]   RND_BOUNCE = (PW+1)'(W_ONE) << 5;

   ease_state_type state_ff, state_in;

   logic [MODE_W-1:0]    mode_ff;
   logic                 lower_ff;
   logic [FRAC_BITS-1:0] t_ff;
   logic [XW-1:0]        x_ff, x_in;
   logic [XW-1:0]        a_ff;
   logic [XW-1:0]        base_ff, base_in;
   logic [PW-1:0]        prod_ff;
   logic [FRAC_BITS:0]   result_ff, result_in;
   logic                 done_ff;

   logic [XW-1:0] t_x, u_x;
   logic          lower_in;
   logic [WW-1:0] t_w, w, w_diff, k_w;
   logic [XW-1:0] s;
   logic [PW:0]   rnd_sum, bnc_sum;
   logic [XW-1:0] rnd_val, bnc_val, scaled, curve, sat;
   logic          is_cubic;
   logic          mul_en, load_sq, finish;

   // Operand selection and bounce segment lookup, taken when a job starts.
   always_comb begin
      t_x      = XW'(t);
      u_x      = ONE - t_x;
      lower_in = t_x < HALF;
      t_w      = WW'(t);
      w        = (t_w << 4) + (t_w << 2) + (t_w << 1);
      if (w < (W_ONE << 3)) begin
         k_w     = '0;
         base_in = '0;
      end else if (w < (W_ONE << 4)) begin
         k_w     = W_ONE * WW'(12);
         base_in = BASE1;
      end else if (w < (W_ONE * WW'(20))) begin
         k_w     = W_ONE * WW'(18);
         base_in = BASE2;
      end else begin
         k_w     = W_ONE * WW'(21);
         base_in = BASE3;
      end
      w_diff = (w >= k_w) ? (w - k_w) : (k_w - w);
      s      = w_diff[XW-1:0];
      case (mode)
         EASE_QUAD_IN, EASE_CUBIC_IN:   x_in = t_x;
         EASE_QUAD_OUT, EASE_CUBIC_OUT: x_in = u_x;
         EASE_QUAD_IO, EASE_CUBIC_IO:   x_in = lower_in ? t_x : u_x;
         EASE_BOUNCE:                   x_in = s;
         default:                       x_in = t_x;
      endcase
   end

   // Rounding of the product register and the final curve combine.
   always_comb begin
      is_cubic = mode_ff inside {EASE_CUBIC_IN, EASE_CUBIC_OUT, EASE_CUBIC_IO};
      rnd_sum  = {1'b0, prod_ff} + RND_HALF;
      rnd_val  = rnd_sum[FRAC_BITS +: XW];
      bnc_sum  = {1'b0, prod_ff} + RND_BOUNCE;
      bnc_val  = base_ff + XW'(bnc_sum[PW:FRAC_BITS + 6]);
      scaled   = is_cubic ? (rnd_val << 2) : (rnd_val << 1);
      case (mode_ff)
         EASE_QUAD_IN, EASE_CUBIC_IN:   curve = rnd_val;
         EASE_QUAD_OUT, EASE_CUBIC_OUT: curve = ONE - rnd_val;
         EASE_QUAD_IO, EASE_CUBIC_IO:   curve = lower_ff ? scaled : (ONE - scaled);
         EASE_BOUNCE:                   curve = bnc_val;
         default:                       curve = XW'(t_ff);
      endcase
      sat = (curve > ONE) ? ONE : curve;
      if (state_ff == E_IDLE) begin
         result_in = (FRAC_BITS+1)'(t);
      end else begin
         result_in = sat[FRAC_BITS:0];
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         E_IDLE: begin
            if (start && (mode != EASE_LINEAR)) begin
               state_in = E_MUL1;
            end
         end
         E_MUL1: state_in = E_RND1;
         E_RND1: state_in = is_cubic ? E_MUL2 : E_IDLE;
         E_MUL2: state_in = E_RND2;
         E_RND2: state_in = E_IDLE;
         default: state_in = E_IDLE;
      endcase
   end

   always_comb begin
      mul_en  = 1'b0;
      load_sq = 1'b0;
      finish  = 1'b0;
      unique case (state_ff)
         E_IDLE: finish = start && (mode == EASE_LINEAR);
         E_MUL1, E_MUL2: mul_en = 1'b1;
         E_RND1: begin
            load_sq = is_cubic;
            finish  = !is_cubic;
         end
         E_RND2: finish = 1'b1;
         default: finish = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= E_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= finish;
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == E_IDLE) && start) begin
         mode_ff  <= mode;
         lower_ff <= lower_in;
         t_ff     <= t;
         x_ff     <= x_in;
         a_ff     <= x_in;
         base_ff  <= base_in;
      end else if (load_sq) begin
         a_ff <= rnd_val;
      end
      if (mul_en) begin
         prod_ff <= a_ff * x_ff;
      end
      if (finish) begin
         result_ff <= result_in;
      end
   end

   assign done   = done_ff;
   assign result = result_ff;

endmodule

`default_nettype wire

[bench/eased_animation_progress_core_tb.sv]
// Self-checking bench for the eased animation progress core: directed table, then random
// animations. Depends on eap_pkg, the channel interfaces in eap_if and the core RTL.
module eased_animation_progress_core_tb;
   import eap_pkg::*;

   localparam int PROG_FRAC = FRAC_BITS_DEF;
   localparam longint unsigned UNIT = 64'd1 << PROG_FRAC;
   localparam longint unsigned HALF = UNIT >> 1;
   // Quiet cycles tolerated before the run is declared hung. The slowest correct beat is a
   // long sender gap, a running tick through divider and easing unit and a long receiver stall.
   localparam int QUIET_LIMIT = 2000;
   // The request field allows a fourth operation code, which the core must ignore.
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   typedef logic [PROG_FRAC:0] prog_type;

   // One response beat as the core reports it.
   typedef struct packed {
      prog_type progress;
      logic     running;
      logic     active;
   } progress_beat_type;

   // Per request beat: whether the table typed in the response by hand.
   typedef struct packed {
      bit                given;
      progress_beat_type want;
   } typed_note_type;

   typedef enum logic [1:0] {ROW_BEAT, ROW_DUR, ROW_MODE} row_kind_type;

   // One row of the directed table: a request beat or a register write.
   typedef struct packed {
      row_kind_type      kind;
      logic [OP_W-1:0]   op;
      logic [TIME_W-1:0] stamp;
      logic [CSR_W-1:0]  value;
      bit                given;
      prog_type          want_progress;
      logic              want_running;
      logic              want_active;
   } row_type;

   localparam prog_type ZERO = '0;
   localparam prog_type FULL = prog_type'(UNIT);

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0] csr_wdata;

   eap_req_if req_ch ();
   eap_rsp_if #(.FRAC_BITS(PROG_FRAC)) rsp_ch ();

   eased_animation_progress_core #(.FRAC_BITS(PROG_FRAC)) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_ch),
      .rsp_bus   (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #10 clock = ~clock;

   // Shadow of the core: register copies and animation state, all at reset values.
   logic [DUR_W-1:0]  cfg_duration = '0;
   logic [MODE_W-1:0] cfg_mode = '0;
   logic [TIME_W-1:0] anim_stamp = '0;
   prog_type          anim_progress = '0;
   logic              anim_active = 1'b0;

   progress_beat_type progress_due_q[$];
   typed_note_type    typed_note_q[$];

   int send_idle_pct = 0;
   int take_idle_pct = 0;
   int beats_sent = 0;
   int beats_outstanding = 0;
   int results_checked = 0;
   int running_seen = 0;
   int settings_applied = 0;
   int fault_count = 0;
   int quiet_cycles = 0;

   row_type dir_plan [0:30];

   // Fixed-point helpers of the easing curves, all in unsigned Q0.PROG_FRAC with
   // round-to-nearest after every product.
   function automatic longint unsigned square_q(input longint unsigned x);
      return (x * x + HALF) >> PROG_FRAC;
   endfunction

   function automatic longint unsigned cube_q(input longint unsigned x);
      return (square_q(x) * x + HALF) >> PROG_FRAC;
   endfunction

   // Bounce out: four parabolic arcs of slope 7.5625, picked by 22*t against the
   // arc boundaries 8, 16 and 20 (in units of 1.0), each centered on its own offset.
   function automatic longint unsigned bounce_q(input longint unsigned t);
      longint unsigned w, center, base, gap;
      w = 22 * t;
      if (w < 8 * UNIT) begin
         center = 0;
         base = 0;
      end else if (w < 16 * UNIT) begin
         center = 12 * UNIT;
         base = 3 * (UNIT >> 2);
      end else if (w < 20 * UNIT) begin
         center = 18 * UNIT;
         base = 15 * (UNIT >> 4);
      end else begin
         center = 21 * UNIT;
         base = 63 * (UNIT >> 6);
      end
      gap = (w >= center) ? w - center : center - w;
      return base + ((gap * gap + 32 * UNIT) >> (PROG_FRAC + 6));
   endfunction

   function automatic longint unsigned eased_q(input logic [MODE_W-1:0] mode,
                                               input longint unsigned t);
      longint unsigned rest, r;
      rest = UNIT - t;
      case (mode)
         EASE_QUAD_IN:   r = square_q(t);
         EASE_QUAD_OUT:  r = UNIT - square_q(rest);
         EASE_QUAD_IO:   r = (t < HALF) ? 2 * square_q(t) : UNIT - 2 * square_q(rest);
         EASE_CUBIC_IN:  r = cube_q(t);
         EASE_CUBIC_OUT: r = UNIT - cube_q(rest);
         EASE_CUBIC_IO:  r = (t < HALF) ? 4 * cube_q(t) : UNIT - 4 * cube_q(rest);
         EASE_BOUNCE:    r = bounce_q(t);
         default:        r = t;
      endcase
      return (r > UNIT) ? UNIT : r;
   endfunction

   // Applies one accepted request beat to the shadow state and returns the response
   // the core owes for it.
   function automatic progress_beat_type advance_animation(input logic [OP_W-1:0] op,
                                                           input logic [TIME_W-1:0] now);
      progress_beat_type r;
      logic [TIME_W-1:0] elapsed;
      longint unsigned t_q;
      r.running = 1'b0;
      case (op)
         OP_START: begin
            anim_stamp = now;
            anim_progress = '0;
            anim_active = 1'b1;
         end
         OP_STOP: anim_active = 1'b0;
         OP_TICK: begin
            if (anim_active) begin
               // The subtraction wraps at 32 bits, so a stamp near the top of the
               // range still gives a small elapsed time.
               elapsed = now - anim_stamp;
               if (elapsed >= cfg_duration) begin
                  anim_progress = FULL;
                  anim_active = 1'b0;
               end else begin
                  t_q = (64'(elapsed) << PROG_FRAC) / 64'(cfg_duration);
                  anim_progress = prog_type'(eased_q(cfg_mode, t_q));
                  r.running = 1'b1;
               end
            end
         end
         default: ;
      endcase
      r.progress = anim_progress;
      r.active = anim_active;
      return r;
   endfunction

   // Every edge with a request handshake advances the shadow state. Rows of the directed
   // table that typed in a response replace the computed one as the expectation.
   always @(posedge clock) begin : track_requests
      progress_beat_type computed;
      typed_note_type note;
      if (!reset && req_ch.valid && req_ch.ready) begin
         computed = advance_animation(req_ch.op, req_ch.current_time);
         note = '0;
         if (typed_note_q.size() != 0)
            note = typed_note_q.pop_front();
         progress_due_q = {progress_due_q, (note.given ? note.want : computed)};
      end
   end

   // Each response beat is held against the oldest expectation, field by field.
   always @(posedge clock) begin : check_progress
      progress_beat_type due;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (progress_due_q.size() == 0) begin
            fault_count++;
            $display("%0t: response beat with none expected: got progress %0d running %0b",
                     $time, rsp_ch.progress, rsp_ch.running);
            $display("%0t: and active %0b", $time, rsp_ch.active);
         end else begin
            due = progress_due_q.pop_front();
            beats_outstanding--;
            results_checked++;
            if (rsp_ch.running === 1'b1)
               running_seen++;
            if (rsp_ch.progress !== due.progress) begin
               fault_count++;
               $display("%0t: progress expected %0d got %0d", $time, due.progress,
                        rsp_ch.progress);
            end
            if (rsp_ch.running !== due.running) begin
               fault_count++;
               $display("%0t: running expected %0b got %0b", $time, due.running,
                        rsp_ch.running);
            end
            if (rsp_ch.active !== due.active) begin
               fault_count++;
               $display("%0t: active expected %0b got %0b", $time, due.active, rsp_ch.active);
            end
         end
      end
   end

   // The receiver stalls at random, at whatever rate the current phase sets.
   always @(posedge clock)
      rsp_ch.ready <= ($urandom_range(99) >= take_idle_pct);

   // Watchdog: any handshake on either channel counts as progress.
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: no beat moved for %0d cycles, giving up", $time, quiet_cycles);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Offers one request beat after a random idle gap and returns at the edge where it
   // is taken. Valid stays high on return so that a following beat can go out back to
   // back; settle_block or the next gap lowers it.
   task automatic send_beat(input logic [OP_W-1:0] op, input logic [TIME_W-1:0] stamp,
                            input bit given = 1'b0, input progress_beat_type want = '0);
      typed_note_type note;
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      note.given = given;
      note.want = want;
      typed_note_q = {typed_note_q, note};
      beats_outstanding++;
      beats_sent++;
      req_ch.valid <= 1'b1;
      req_ch.op <= op;
      req_ch.current_time <= stamp;
      @(posedge clock);
      while (!req_ch.ready)
         @(posedge clock);
   endtask

   // Stops offering beats and waits until every response has come back. Every beat
   // owes exactly one response, so the core is idle once the count reaches zero.
   task automatic settle_block();
      req_ch.valid <= 1'b0;
      while (beats_outstanding != 0)
         @(posedge clock);
   endtask

   // One register write; the enable is lowered on the following edge so that two
   // writes in a row never assign it twice in one step.
   task automatic write_csr(input logic [CSR_IDX_W-1:0] index, input logic [CSR_W-1:0] data);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      case (index)
         REG_DURATION: cfg_duration = DUR_W'(data);
         REG_EASING:   cfg_mode = MODE_W'(data);
         default: ;
      endcase
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // A start followed by ticks whose elapsed time creeps toward and past the duration,
   // salted with stops, restarts, unused codes and ticks at arbitrary times.
   task automatic play_animation(input logic [DUR_W-1:0] dur);
      logic [TIME_W-1:0] origin;
      logic [TIME_W-1:0] elapsed;
      int unsigned stride;
      int unsigned pick;
      origin = $urandom;
      // A quarter of the animations start close enough to the top of the time range
      // that their ticks wrap around zero.
      if ($urandom_range(3) == 0)
         origin = '1 - TIME_W'($urandom_range(dur));
      stride = dur / 6 + 1;
      elapsed = '0;
      send_beat(OP_START, origin);
      repeat ($urandom_range(12, 3)) begin
         pick = $urandom_range(99);
         if (pick < 80) begin
            elapsed += $urandom_range(stride);
            send_beat(OP_TICK, origin + elapsed);
         end else if (pick < 87) begin
            send_beat(OP_STOP, $urandom);
         end else if (pick < 93) begin
            origin = $urandom;
            elapsed = '0;
            send_beat(OP_START, origin);
         end else if (pick < 96) begin
            send_beat(OP_UNUSED, $urandom);
         end else begin
            send_beat(OP_TICK, $urandom);
         end
      end
   endtask

   // Random animations under a fresh register setting each round, until the beat
   // count reaches the given mark. Durations lean toward the extremes and short values
   // so that animations actually finish; long ones exercise the fine end of the divide.
   task automatic run_random(input int upto);
      logic [DUR_W-1:0] dur;
      logic [MODE_W-1:0] mode;
      while (beats_sent < upto) begin
         case ($urandom_range(9))
            0: dur = '0;
            1: dur = DUR_W'(1);
            2: dur = '1;
            3: dur = DUR_W'($urandom_range(20, 2));
            4, 5: dur = DUR_W'($urandom_range(1000, 21));
            default: dur = DUR_W'($urandom);
         endcase
         mode = MODE_W'($urandom_range(7));
         settle_block();
         write_csr(REG_DURATION, CSR_W'(dur));
         write_csr(REG_EASING, CSR_W'(mode));
         settings_applied++;
         repeat ($urandom_range(4, 1))
            play_animation(dur);
      end
   endtask

   initial begin
      // Directed table. Responses that follow directly from the rules (idle core,
      // starts, a zero duration, elapsed equal to the duration) are typed in; the rest
      // come from the shadow model.
      dir_plan = '{
         // Tick while inactive, stop while inactive and the unused code, straight after reset.
         '{ROW_BEAT, OP_TICK,   32'h0000_0000, 16'd0, 1'b1, ZERO, 1'b0, 1'b0},
         '{ROW_BEAT, OP_STOP,   32'h0000_0000, 16'd0, 1'b1, ZERO, 1'b0, 1'b0},
         '{ROW_BEAT, OP_UNUSED, 32'hFFFF_FFFF, 16'd0, 1'b1, ZERO, 1'b0, 1'b0},
         // Duration is still zero, so the first tick finishes the animation.
         '{ROW_BEAT, OP_START,  32'hFFFF_FFFF, 16'd0, 1'b1, ZERO, 1'b0, 1'b1},
         '{ROW_BEAT, OP_TICK,   32'h0000_0005, 16'd0, 1'b1, FULL, 1'b0, 1'b0},
         '{ROW_DUR,  OP_START,  32'h0000_0000, 16'hFFFF, 1'b0, ZERO, 1'b0, 1'b0},
         // Linear at the longest duration: zero elapsed, then a tick across the time wrap
         // that lands just short of the end.
         '{ROW_BEAT, OP_START,  32'hFFFF_FFF0, 16'd0, 1'b1, ZERO, 1'b0, 1'b1},
         '{ROW_BEAT, OP_TICK,   32'hFFFF_FFF0, 16'd0, 1'b1, ZERO, 1'b1, 1'b1},
         '{ROW_BEAT, OP_TICK,   32'h0000_FFEE, 16'd0, 1'b0, ZERO, 1'b0, 1'b0},
         // Stop keeps the progress; the next tick finds nothing active.
         '{ROW_BEAT, OP_STOP,   32'h1234_5678, 16'd0, 1'b0, ZERO, 1'b0, 1'b0},
         '{ROW_BEAT, OP_TICK,   32'h0000_FFFE, 16'd0, 1'b0, ZERO, 1'b0, 1'b0},
         // Start while active restarts; elapsed equal to the duration finishes.
         '{ROW_BEAT, OP_START,  32'd100,       16'd0, 1'b1, ZERO, 1'b0, 1'b1},
         '{ROW_BEAT, OP_START,  32'd200,       16'd0, 1'b1, ZERO, 1'b0, 1'b1},
         '{ROW_BEAT, OP_TICK,   32'd200 + 32'd65535, 16'd0, 1'b1, FULL, 1'b0, 1'b0},
         // One long animation; each curve is sampled near an end or near its midpoint.
         '{ROW_BEAT, OP_START,  32'd1000,      16'd0, 1'b1, ZERO, 1'b0, 1'b1},
         '{ROW_MODE, OP_START,  32'd0, 16'(EASE_QUAD_IN),   1'b0, ZERO, 1'b0, 1'b0},
         '{ROW_BEAT, OP_TICK,   32'd1000 + 32'd65534, 16'd0, 1'b0, ZERO, 1'b0, 1'b0},
         '{ROW_MODE, OP_START,  32'd0, 16'(EASE_QUAD_OUT),  1'b0, ZERO, 1'b0, 1'b0},
         '{ROW_BEAT, OP_TICK,   32'd1000 + 32'd1,     16'd0, 1'b0, ZERO, 1'b0, 1'b0},
         '{ROW_MODE, OP_START,  32'd0, 16'(EASE_QUAD_IO),   1'b0, ZERO, 1'b0, 1'b0},
         '{ROW_BEAT, OP_TICK,   32'd1000 + 32'd32767, 16'd0, 1'b0, ZERO, 1'b0, 1'b0},
         '{ROW_MODE, OP_START,  32'd0, 16'(EASE_CUBIC_IN),  1'b0, ZERO, 1'b0, 1'b0},
         '{ROW_BEAT, OP_TICK,   32'd1000 + 32'd65534, 16'd0, 1'b0, ZERO, 1'b0, 1'b0},
         '{ROW_MODE, OP_START,  32'd0, 16'(EASE_CUBIC_OUT), 1'b0, ZERO, 1'b0, 1'b0},
         '{ROW_BEAT, OP_TICK,   32'd1000 + 32'd32768, 16'd0, 1'b0, ZERO, 1'b0, 1'b0},
         '{ROW_MODE, OP_START,  32'd0, 16'(EASE_CUBIC_IO),  1'b0, ZERO, 1'b0, 1'b0},
         '{ROW_BEAT, OP_TICK,   32'd1000 + 32'd32767, 16'd0, 1'b0, ZERO, 1'b0, 1'b0},
         '{ROW_BEAT, OP_TICK,   32'd1000 + 32'd32768, 16'd0, 1'b0, ZERO, 1'b0, 1'b0},
         // Bounce just below its first arc boundary and deep in the last arc.
         '{ROW_MODE, OP_START,  32'd0, 16'(EASE_BOUNCE),    1'b0, ZERO, 1'b0, 1'b0},
         '{ROW_BEAT, OP_TICK,   32'd1000 + 32'd23831, 16'd0, 1'b0, ZERO, 1'b0, 1'b0},
         '{ROW_BEAT, OP_TICK,   32'd1000 + 32'd65534, 16'd0, 1'b0, ZERO, 1'b0, 1'b0}
      };

      // Every input starts at a known value; reset is asserted once, at the start.
      req_ch.valid = 1'b0;
      req_ch.op = OP_START;
      req_ch.current_time = '0;
      rsp_ch.ready = 1'b0;
      csr_we = 1'b0;
      csr_index = REG_DURATION;
      csr_wdata = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // First phase: the sender idles with a chance of 31 in a hundred, the receiver with 54.
      send_idle_pct = 31;
      take_idle_pct = 54;
      foreach (dir_plan[i]) begin
         case (dir_plan[i].kind)
            ROW_DUR: begin
               settle_block();
               write_csr(REG_DURATION, dir_plan[i].value);
            end
            ROW_MODE: begin
               settle_block();
               write_csr(REG_EASING, dir_plan[i].value);
            end
            default: send_beat(dir_plan[i].op, dir_plan[i].stamp, dir_plan[i].given,
                               '{dir_plan[i].want_progress, dir_plan[i].want_running,
                                 dir_plan[i].want_active});
         endcase
      end
      run_random(340);

      // Second phase swaps the idle rates; the third runs at full speed on both sides.
      send_idle_pct = 54;
      take_idle_pct = 31;
      run_random(660);
      send_idle_pct = 0;
      take_idle_pct = 0;
      run_random(940);

      // Drain, then leave room for any stray response to show up.
      settle_block();
      repeat (2 * PROG_FRAC + 20) @(posedge clock);
      fault_count += progress_due_q.size();

      $display("Run covered %0d request beats over %0d random register settings.",
               beats_sent, settings_applied);
      $display("%0d response beats checked, %0d of them mid-animation; %0d mismatches.",
               results_checked, running_seen, fault_count);
      if (fault_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
